// ----- design/wrp_pkg.sv -----
// Package with the shared types, widths and constants of the windowed repetition penalty core.
package wrp_pkg;

  localparam int WINDOW_DEPTH_DEF = 64;
  localparam int TOKEN_BITS_DEF   = 17;

  localparam int LOGIT_W = 32;
  localparam int PEN_W   = 16;
  localparam int WLEN_W  = 7;
  localparam int OCC_W   = 7;
  localparam int ACC_W   = 50;
  localparam int DIVD_W  = LOGIT_W - 1 + 8;
  localparam int QCNT_W  = $clog2(DIVD_W);

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(64);
  localparam logic [PEN_W-1:0]  PEN_ONE    = PEN_W'(256);
  localparam logic [PEN_W-1:0]  PEN_ZERO   = '0;

  localparam logic signed [ACC_W-1:0] SAT_MAX =
    {{(ACC_W - LOGIT_W + 1){1'b0}}, {(LOGIT_W - 1){1'b1}}};
  localparam logic signed [ACC_W-1:0] SAT_MIN =
    {{(ACC_W - LOGIT_W + 1){1'b1}}, {(LOGIT_W - 1){1'b0}}};

  typedef enum logic {
    CMD_ACCEPT   = 1'b0,
    CMD_PENALIZE = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    REG_WINDOW_LENGTH     = 2'd0,
    REG_REPEAT_PENALTY    = 2'd1,
    REG_FREQUENCY_PENALTY = 2'd2,
    REG_PRESENCE_PENALTY  = 2'd3
  } cfg_reg_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_ACC_CHK,
    S_ACC_OLD,
    S_ACC_DEC,
    S_ACC_TOK,
    S_ACC_INC,
    S_PEN_RD,
    S_PEN_CNT,
    S_PEN_MUL,
    S_PEN_SCALE,
    S_PEN_DIV,
    S_PEN_FREQ,
    S_PEN_SUM,
    S_PEN_OUT
  } state_e;

endpackage

// ----- design/wrp_div.sv -----
// Radix-2 restoring divider that produces one quotient bit per cycle.
module wrp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [wrp_pkg::DIVD_W-1:0] dividend_i,
  input  logic [wrp_pkg::PEN_W-1:0]  divisor_i,
  output logic                       done_o,
  output logic [wrp_pkg::DIVD_W-1:0] quotient_o
);

  localparam int DW = wrp_pkg::DIVD_W;
  localparam int PW = wrp_pkg::PEN_W;
  localparam int CW = wrp_pkg::QCNT_W;

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic [DW-1:0] shreg_q;
  logic [PW-1:0] rem_q;
  logic [PW-1:0] div_q;
  logic [PW:0]   shifted;
  logic [PW:0]   trial;
  logic          take;

  always_comb begin
    shifted = {rem_q, shreg_q[DW-1]};
    trial   = shifted - {1'b0, div_q};
    take    = ~trial[PW];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW - 1);
      end else if (busy_q) begin
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          cnt_q <= cnt_q - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      shreg_q <= dividend_i;
      rem_q   <= '0;
      div_q   <= divisor_i;
    end else if (busy_q) begin
      shreg_q <= {shreg_q[DW-2:0], take};
      rem_q   <= take ? trial[PW-1:0] : shifted[PW-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = shreg_q;

endmodule

// ----- design/windowed_repetition_penalty_core.sv -----
// Top level of the windowed repetition penalty core: window, count table and sequencer.
//
// The input channel (in_valid_i / in_ready_o) carries one command per transaction. An accept
// command pushes token_id_i into the sliding window, evicting the oldest token once the window
// holds window_length tokens, and produces no result. A penalize command produces exactly one
// result transaction on the output channel (out_valid_o / out_ready_i) with the penalized logit,
// the token's occurrence count and a flag telling whether a penalty was applied.
// After reset the count table is cleared one entry per cycle through all 2^TOKEN_BITS entries;
// in_ready_o stays low meanwhile, while configuration writes are taken as usual.
// An accept command reads the oldest token from the window and decrements its count, then reads
// and increments the new token's count and writes the token into the window when the oldest token
// is evicted; while the window still grows it skips the oldest token, and when it is disabled it
// does nothing. A penalize command reads the token's count, then passes the logit unchanged or
// takes its own path for a positive logit under a zero repeat penalty, a non-positive logit or
// any other positive logit, the last through the radix-2 divider producing one of its 39 quotient
// bits per cycle. The count table is a single-port memory, so each table access is a step of its own.
// The result sits in an output register. New commands are accepted while it waits; a later
// penalize command that finishes before the receiver takes the pending result holds in its
// last step until the output register is free.
module windowed_repetition_penalty_core #(
  parameter int WINDOW_DEPTH = wrp_pkg::WINDOW_DEPTH_DEF,
  parameter int TOKEN_BITS   = wrp_pkg::TOKEN_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [1:0]                        cfg_idx_i,
  input  logic [wrp_pkg::PEN_W-1:0]         cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              cmd_i,
  input  logic [TOKEN_BITS-1:0]             token_id_i,
  input  logic signed [wrp_pkg::LOGIT_W-1:0] logit_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [wrp_pkg::LOGIT_W-1:0] logit_out_o,
  output logic [wrp_pkg::OCC_W-1:0]         occurrences_o,
  output logic                              penalized_o
);

  localparam int TBL_DEPTH = 1 << TOKEN_BITS;
  localparam int PTR_W  = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int CNT_W  = FILL_W;
  localparam int IDX_W  = FILL_W + 1;
  localparam int LEN_W  = (wrp_pkg::WLEN_W > FILL_W) ? wrp_pkg::WLEN_W : FILL_W;
  localparam int LW     = wrp_pkg::LOGIT_W;
  localparam int PW     = wrp_pkg::PEN_W;
  localparam int AW     = wrp_pkg::ACC_W;

  wrp_pkg::state_e state_q, state_d;

  logic [wrp_pkg::WLEN_W-1:0] wl_q;
  logic [PW-1:0]              rp_q;
  logic signed [PW-1:0]       freq_q;
  logic signed [PW-1:0]       pres_q;

  logic [TOKEN_BITS-1:0] clr_q, clr_d;
  logic [PTR_W-1:0]      wp_q, wp_d;
  logic [FILL_W-1:0]     fill_q, fill_d;
  logic                  evict_q, evict_d;
  logic                  out_valid_q, out_valid_d;

  logic [TOKEN_BITS-1:0] tok_q, tok_d;
  logic signed [LW-1:0]  x_q, x_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic                  apply_q, apply_d;
  logic signed [AW-1:0]  prod_q, prod_d;
  logic signed [AW-1:0]  acc_q, acc_d;

  logic signed [LW-1:0]        logit_out_q, logit_out_d;
  logic [wrp_pkg::OCC_W-1:0]   occ_q, occ_d;
  logic                        pen_q, pen_d;

  logic [CNT_W-1:0]      tbl_mem [TBL_DEPTH];
  logic [CNT_W-1:0]      tbl_rdata_q;
  logic [TOKEN_BITS-1:0] tbl_addr;
  logic [CNT_W-1:0]      tbl_wdata;
  logic                  tbl_we;
  logic                  tbl_re;

  logic [TOKEN_BITS-1:0] ring_mem [WINDOW_DEPTH];
  logic [TOKEN_BITS-1:0] ring_rdata_q;
  logic [PTR_W-1:0]      ring_addr;
  logic                  ring_we;
  logic                  ring_re;

  logic                  in_fire;
  logic [LEN_W-1:0]      eff_len;
  logic [IDX_W-1:0]      old_sum;
  logic [PTR_W-1:0]      oldest;
  logic                  neutral;
  logic                  apply_now;
  logic                  x_nonpos;

  logic signed [32:0]    mul_a;
  logic signed [16:0]    mul_b;
  logic signed [AW-1:0]  mul_p;
  logic signed [AW-1:0]  neg_p;
  logic signed [AW-1:0]  term;
  logic signed [AW-1:0]  diff;

  logic                  div_start;
  logic                  div_done;
  logic [wrp_pkg::DIVD_W-1:0] div_quot;
  logic [wrp_pkg::DIVD_W-1:0] div_dividend;

  assign in_ready_o = (state_q == wrp_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    eff_len = (LEN_W'(wl_q) > LEN_W'(WINDOW_DEPTH)) ? LEN_W'(WINDOW_DEPTH) : LEN_W'(wl_q);
    old_sum = IDX_W'(wp_q) + IDX_W'(WINDOW_DEPTH) - IDX_W'(fill_q);
    oldest  = (old_sum >= IDX_W'(WINDOW_DEPTH)) ? PTR_W'(old_sum - IDX_W'(WINDOW_DEPTH))
                                                : PTR_W'(old_sum);
    neutral = (rp_q == wrp_pkg::PEN_ONE) && (freq_q == $signed(wrp_pkg::PEN_ZERO)) &&
              (pres_q == $signed(wrp_pkg::PEN_ZERO));
    apply_now = (eff_len != '0) && (tbl_rdata_q != '0) && !neutral;
    x_nonpos  = x_q[LW-1] || (x_q == '0);
    div_dividend = {x_q[LW-2:0], 8'b0};
  end

  assign mul_p = mul_a * mul_b;

  wrp_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (rp_q),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_addr] <= tbl_wdata;
    end
    if (tbl_re) begin
      tbl_rdata_q <= tbl_mem[tbl_addr];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_addr] <= tok_q;
    end
    if (ring_re) begin
      ring_rdata_q <= ring_mem[ring_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= wrp_pkg::WLEN_RESET;
      rp_q   <= wrp_pkg::PEN_ONE;
      freq_q <= '0;
      pres_q <= '0;
    end else if (cfg_we_i) begin
      unique case (wrp_pkg::cfg_reg_e'(cfg_idx_i))
        wrp_pkg::REG_WINDOW_LENGTH:     wl_q   <= cfg_data_i[wrp_pkg::WLEN_W-1:0];
        wrp_pkg::REG_REPEAT_PENALTY:    rp_q   <= cfg_data_i;
        wrp_pkg::REG_FREQUENCY_PENALTY: freq_q <= $signed(cfg_data_i);
        wrp_pkg::REG_PRESENCE_PENALTY:  pres_q <= $signed(cfg_data_i);
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wrp_pkg::S_CLEAR;
      clr_q       <= '0;
      wp_q        <= '0;
      fill_q      <= '0;
      evict_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      wp_q        <= wp_d;
      fill_q      <= fill_d;
      evict_q     <= evict_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tok_q       <= tok_d;
    x_q         <= x_d;
    cnt_q       <= cnt_d;
    apply_q     <= apply_d;
    prod_q      <= prod_d;
    acc_q       <= acc_d;
    logit_out_q <= logit_out_d;
    occ_q       <= occ_d;
    pen_q       <= pen_d;
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    wp_d        = wp_q;
    fill_d      = fill_q;
    evict_d     = evict_q;
    out_valid_d = out_valid_q;
    tok_d       = tok_q;
    x_d         = x_q;
    cnt_d       = cnt_q;
    apply_d     = apply_q;
    prod_d      = prod_q;
    acc_d       = acc_q;
    logit_out_d = logit_out_q;
    occ_d       = occ_q;
    pen_d       = pen_q;
    tbl_addr    = tok_q;
    tbl_wdata   = tbl_rdata_q;
    tbl_we      = 1'b0;
    tbl_re      = 1'b0;
    ring_addr   = wp_q;
    ring_we     = 1'b0;
    ring_re     = 1'b0;
    div_start   = 1'b0;
    mul_a       = 33'(x_q);
    mul_b       = $signed({1'b0, rp_q});
    neg_p       = -prod_q;
    term        = (prod_q + AW'(pres_q)) <<< 8;
    diff        = acc_q - term;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      wrp_pkg::S_CLEAR: begin
        tbl_we    = 1'b1;
        tbl_addr  = clr_q;
        tbl_wdata = '0;
        clr_d     = clr_q + 1'b1;
        if (clr_q == '1) begin
          state_d = wrp_pkg::S_IDLE;
        end
      end
      wrp_pkg::S_IDLE: begin
        if (in_fire) begin
          tok_d = token_id_i;
          x_d   = logit_in_i;
          if (wrp_pkg::cmd_e'(cmd_i) == wrp_pkg::CMD_ACCEPT) begin
            state_d = wrp_pkg::S_ACC_CHK;
          end else begin
            state_d = wrp_pkg::S_PEN_RD;
          end
        end
      end
      wrp_pkg::S_ACC_CHK: begin
        if (eff_len == '0) begin
          state_d = wrp_pkg::S_IDLE;
        end else if (LEN_W'(fill_q) >= eff_len) begin
          evict_d   = 1'b1;
          ring_re   = 1'b1;
          ring_addr = oldest;
          state_d   = wrp_pkg::S_ACC_OLD;
        end else begin
          evict_d = 1'b0;
          state_d = wrp_pkg::S_ACC_TOK;
        end
      end
      wrp_pkg::S_ACC_OLD: begin
        tbl_re   = 1'b1;
        tbl_addr = ring_rdata_q;
        state_d  = wrp_pkg::S_ACC_DEC;
      end
      wrp_pkg::S_ACC_DEC: begin
        tbl_addr  = ring_rdata_q;
        tbl_wdata = tbl_rdata_q - 1'b1;
        tbl_we    = (tbl_rdata_q != '0);
        state_d   = wrp_pkg::S_ACC_TOK;
      end
      wrp_pkg::S_ACC_TOK: begin
        tbl_re  = 1'b1;
        state_d = wrp_pkg::S_ACC_INC;
      end
      wrp_pkg::S_ACC_INC: begin
        tbl_we    = 1'b1;
        tbl_wdata = tbl_rdata_q + 1'b1;
        ring_we   = 1'b1;
        wp_d      = (wp_q == PTR_W'(WINDOW_DEPTH - 1)) ? '0 : wp_q + 1'b1;
        if (!evict_q) begin
          fill_d = fill_q + 1'b1;
        end
        state_d = wrp_pkg::S_IDLE;
      end
      wrp_pkg::S_PEN_RD: begin
        tbl_re  = 1'b1;
        state_d = wrp_pkg::S_PEN_CNT;
      end
      wrp_pkg::S_PEN_CNT: begin
        cnt_d   = tbl_rdata_q;
        apply_d = apply_now;
        if (!apply_now) begin
          acc_d   = AW'(x_q);
          state_d = wrp_pkg::S_PEN_OUT;
        end else if (x_nonpos) begin
          state_d = wrp_pkg::S_PEN_MUL;
        end else if (rp_q == '0) begin
          acc_d   = wrp_pkg::SAT_MAX;
          state_d = wrp_pkg::S_PEN_FREQ;
        end else begin
          div_start = 1'b1;
          state_d   = wrp_pkg::S_PEN_DIV;
        end
      end
      wrp_pkg::S_PEN_MUL: begin
        prod_d  = mul_p;
        state_d = wrp_pkg::S_PEN_SCALE;
      end
      wrp_pkg::S_PEN_SCALE: begin
        acc_d   = -(neg_p >>> 8);
        state_d = wrp_pkg::S_PEN_FREQ;
      end
      wrp_pkg::S_PEN_DIV: begin
        if (div_done) begin
          acc_d   = $signed(AW'(div_quot));
          state_d = wrp_pkg::S_PEN_FREQ;
        end
      end
      wrp_pkg::S_PEN_FREQ: begin
        mul_a   = $signed(33'(cnt_q));
        mul_b   = 17'(freq_q);
        prod_d  = mul_p;
        state_d = wrp_pkg::S_PEN_SUM;
      end
      wrp_pkg::S_PEN_SUM: begin
        if (diff > wrp_pkg::SAT_MAX) begin
          acc_d = wrp_pkg::SAT_MAX;
        end else if (diff < wrp_pkg::SAT_MIN) begin
          acc_d = wrp_pkg::SAT_MIN;
        end else begin
          acc_d = diff;
        end
        state_d = wrp_pkg::S_PEN_OUT;
      end
      wrp_pkg::S_PEN_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          logit_out_d = acc_q[LW-1:0];
          occ_d       = wrp_pkg::OCC_W'(cnt_q);
          pen_d       = apply_q;
          out_valid_d = 1'b1;
          state_d     = wrp_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = wrp_pkg::S_IDLE;
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign logit_out_o   = logit_out_q;
  assign occurrences_o = occ_q;
  assign penalized_o   = pen_q;

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> !in_ready_o
  ) else $error("Block stayed ready right after taking a command.");

  a_fill_grows: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == wrp_pkg::S_ACC_INC && !evict_q) |=>
      (fill_q == FILL_W'($past(fill_q) + 1'b1))
  ) else $error("Window fill did not grow on an accept without eviction.");

  a_result_posted: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q == wrp_pkg::S_PEN_OUT && (!out_valid_q || out_ready_i)) |=> out_valid_o
  ) else $error("Finished penalize command did not post a result.");

  a_no_clear_after_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (state_q != wrp_pkg::S_CLEAR) |=> (state_q != wrp_pkg::S_CLEAR)
  ) else $error("Table clearing restarted outside of reset.");

endmodule
